### src/btm_pkg.sv
`default_nettype none

package btm_pkg;

	localparam int unsigned MAX_SIZE = 64;

	localparam int SIZE_W  = 7;
	localparam int SHAPE_W = 2;
	localparam int HARD_W  = 8;
	localparam int COORD_W = 6;
	localparam int ALPHA_W = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// Working widths of the soft falloff search.
	localparam int W_W  = 24;
	localparam int M_W  = 14;
	localparam int SQ_W = 48;
	localparam int D2_W = 15;

	localparam logic [ALPHA_W-1:0] ALPHA_FULL = 8'hFF;
	localparam logic [ALPHA_W-1:0] ALPHA_NONE = 8'h00;

	// 255^2 and 255^4: the Q8 unit of the falloff and its square.
	localparam logic [16:0] Q_ONE    = 17'd65025;
	localparam logic [31:0] Q_ONE_SQ = 32'd4228250625;

	// Angled nib limits: 200*(X+Y)^2 <= (7n+20)^2.
	localparam logic [23:0] NIB_SCALE = 24'd200;
	localparam logic [8:0]  NIB_MUL   = 9'd7;
	localparam logic [8:0]  NIB_ADD   = 9'd20;

	typedef enum logic [SHAPE_W-1:0] {
		SHAPE_ROUND  = 2'd0,
		SHAPE_SOFT   = 2'd1,
		SHAPE_SQUARE = 2'd2,
		SHAPE_ANGLED = 2'd3
	} btm_shape_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BRUSH_SIZE = 2'd0,
		REG_TIP_SHAPE  = 2'd1,
		REG_HARDNESS   = 2'd2
	} btm_reg_t;

	// One item on its way through the falloff search.
	typedef struct packed {
		logic                   vld;
		logic                   srch;
		logic [ALPHA_W-1:0]     a;
		logic [ALPHA_W-1:0]     k;
		logic signed [W_W-1:0]  w;
		logic [M_W-1:0]         m;
		logic [SQ_W-1:0]        dd;
	} btm_srch_t;

endpackage

`default_nettype wire

### src/btm_pix_if.sv
`default_nettype none

interface btm_pix_if import btm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

`default_nettype wire

### src/btm_alpha_if.sv
`default_nettype none

interface btm_alpha_if import btm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ALPHA_W-1:0] alpha;

	modport source (output valid, output alpha, input ready);
	modport sink (input valid, input alpha, output ready);
endinterface

`default_nettype wire

### src/btm_geom.sv
`default_nettype none

module btm_geom import btm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic [COORD_W-1:0] pixel_x,
	input  logic [COORD_W-1:0] pixel_y,
	input  logic [SIZE_W-1:0]  brush_size,
	input  btm_shape_t         tip_shape,
	input  logic [HARD_W-1:0]  hardness,
	output btm_srch_t          res
);

	// Stage 1: captured coordinates.
	logic               vld_s1;
	logic [COORD_W-1:0] px_s1;
	logic [COORD_W-1:0] py_s1;

	// Stage 2: centred doubled coordinates and size products.
	logic               vld_s2;
	logic               oor_s2;
	btm_shape_t         shape_s2;
	logic [SIZE_W-1:0]  n_s2;
	logic signed [7:0]  x_s2;
	logic signed [7:0]  y_s2;
	logic signed [8:0]  sum_s2;
	logic signed [8:0]  diff_s2;
	logic [M_W-1:0]     m_s2;
	logic [M_W-1:0]     nh_s2;

	// Stage 3: squares.
	logic               vld_s3;
	logic               oor_s3;
	btm_shape_t         shape_s3;
	logic [13:0]        xx_s3;
	logic [13:0]        yy_s3;
	logic [15:0]        ss_s3;
	logic [15:0]        df2_s3;
	logic [12:0]        nn_s3;
	logic [17:0]        lim2_s3;
	logic [27:0]        nh2_s3;
	logic [21:0]        w0_s3;
	logic [M_W-1:0]     m_s3;

	// Stage 4: distance and the hard shape decisions.
	logic               vld_s4;
	logic               oor_s4;
	btm_shape_t         shape_s4;
	logic [ALPHA_W-1:0] a_s4;
	logic [D2_W-1:0]    d2_s4;
	logic               disc_s4;
	logic [27:0]        nh2_s4;
	logic [21:0]        w0_s4;
	logic [M_W-1:0]     m_s4;

	// Stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= pixel_x;
			py_s1 <= pixel_y;
		end
	end

	// Stage 2 logic
	logic [SIZE_W-1:0] n_a;
	logic              oor_a;
	logic signed [7:0] x_a;
	logic signed [7:0] y_a;
	logic [14:0]       m_full_a;
	logic [14:0]       nh_full_a;

	always_comb begin
		if (brush_size == '0) begin
			n_a = SIZE_W'(1);
		end else if (brush_size > SIZE_W'(MAX_SIZE)) begin
			n_a = SIZE_W'(MAX_SIZE);
		end else begin
			n_a = brush_size;
		end
	end

	assign oor_a     = ({1'b0, px_s1} >= n_a) || ({1'b0, py_s1} >= n_a);
	assign x_a       = signed'({1'b0, px_s1, 1'b0}) - signed'({1'b0, n_a - SIZE_W'(1)});
	assign y_a       = signed'({1'b0, py_s1, 1'b0}) - signed'({1'b0, n_a - SIZE_W'(1)});
	assign m_full_a  = 15'(n_a) * 15'(8'd255 - hardness);
	assign nh_full_a = 15'(n_a) * 15'(hardness);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oor_s2   <= oor_a;
			shape_s2 <= tip_shape;
			n_s2     <= n_a;
			x_s2     <= x_a;
			y_s2     <= y_a;
			sum_s2   <= {x_a[7], x_a} + {y_a[7], y_a};
			diff_s2  <= {y_a[7], y_a} - {x_a[7], x_a};
			m_s2     <= m_full_a[M_W-1:0];
			nh_s2    <= nh_full_a[M_W-1:0];
		end
	end

	// Stage 3 logic
	logic signed [15:0] xx_b;
	logic signed [15:0] yy_b;
	logic signed [17:0] ss_b;
	logic signed [17:0] df2_b;
	logic [13:0]        nn_b;
	logic [8:0]         lim_b;

	assign xx_b  = x_s2 * x_s2;
	assign yy_b  = y_s2 * y_s2;
	assign ss_b  = sum_s2 * sum_s2;
	assign df2_b = diff_s2 * diff_s2;
	assign nn_b  = 14'(n_s2) * 14'(n_s2);
	assign lim_b = 9'(n_s2) * NIB_MUL + NIB_ADD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oor_s3   <= oor_s2;
			shape_s3 <= shape_s2;
			xx_s3    <= xx_b[13:0];
			yy_s3    <= yy_b[13:0];
			ss_s3    <= ss_b[15:0];
			df2_s3   <= df2_b[15:0];
			nn_s3    <= nn_b[12:0];
			lim2_s3  <= 18'(lim_b) * 18'(lim_b);
			nh2_s3   <= 28'(nh_s2) * 28'(nh_s2);
			w0_s3    <= 22'(n_s2) * 22'(Q_ONE);
			m_s3     <= m_s2;
		end
	end

	// Stage 4 logic
	logic [D2_W-1:0]    d2_c;
	logic               disc_c;
	logic               nib_c;
	logic [ALPHA_W-1:0] a_c;

	assign d2_c   = D2_W'(xx_s3) + D2_W'(yy_s3);
	assign disc_c = d2_c <= D2_W'(nn_s3);
	assign nib_c  = (24'(ss_s3) * NIB_SCALE <= 24'(lim2_s3)) &&
		(df2_s3 <= 16'({nn_s3, 1'b0}));

	always_comb begin
		unique case (shape_s3)
			SHAPE_ROUND:  a_c = disc_c ? ALPHA_FULL : ALPHA_NONE;
			SHAPE_SOFT:   a_c = disc_c ? ALPHA_FULL : ALPHA_NONE;
			SHAPE_SQUARE: a_c = ALPHA_FULL;
			SHAPE_ANGLED: a_c = nib_c ? ALPHA_FULL : ALPHA_NONE;
			default:      a_c = ALPHA_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oor_s4   <= oor_s3;
			shape_s4 <= shape_s3;
			a_s4     <= oor_s3 ? ALPHA_NONE : a_c;
			d2_s4    <= d2_c;
			disc_s4  <= disc_c;
			nh2_s4   <= nh2_s3;
			w0_s4    <= w0_s3;
			m_s4     <= m_s3;
		end
	end

	// Stage 5 logic: soft core test and the squared search bound.
	logic            core_d;
	logic [30:0]     d2q_d;
	btm_srch_t       res_d;

	assign d2q_d  = 31'(d2_s4) * 31'(Q_ONE);
	assign core_d = d2q_d <= 31'(nh2_s4);

	always_comb begin
		res_d.vld  = vld_s4;
		res_d.srch = !oor_s4 && (shape_s4 == SHAPE_SOFT) && disc_s4 && !core_d;
		res_d.a    = a_s4;
		res_d.k    = ALPHA_NONE;
		res_d.w    = signed'(W_W'(w0_s4));
		res_d.m    = m_s4;
		res_d.dd   = SQ_W'(d2_s4) * SQ_W'(Q_ONE_SQ);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res <= '0;
		end else if (en) begin
			res <= res_d;
		end
	end

endmodule

`default_nettype wire

### src/btm_step.sv
`default_nettype none

module btm_step import btm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [2:0] shamt,
	input  btm_srch_t  prev,
	output btm_srch_t  next
);

	btm_srch_t             base_s1;
	logic [ALPHA_W-1:0]    cand_s1;
	logic signed [W_W-1:0] wc_s1;
	logic [SQ_W-1:0]       sq_s1;

	logic [ALPHA_W-1:0]    cand_a;
	logic [W_W-1:0]        mstep_a;
	logic signed [W_W-1:0] wc_a;

	// Try this bit of alpha: the remaining margin shrinks by bit * m.
	assign cand_a  = prev.k | (ALPHA_W'(1) << shamt);
	assign mstep_a = W_W'(prev.m) << shamt;
	assign wc_a    = prev.w - signed'(mstep_a);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_s1 <= '0;
			cand_s1 <= '0;
			wc_s1   <= '0;
			sq_s1   <= '0;
		end else if (en) begin
			base_s1 <= prev;
			cand_s1 <= cand_a;
			wc_s1   <= wc_a;
			sq_s1   <= SQ_W'(wc_a[W_W-2:0]) * SQ_W'(wc_a[W_W-2:0]);
		end
	end

	// The bit is kept when the margin is not negative and covers the radius.
	logic      ok_b;
	btm_srch_t next_b;

	assign ok_b = !wc_s1[W_W-1] && (base_s1.dd <= sq_s1);

	always_comb begin
		next_b = base_s1;
		if (ok_b) begin
			next_b.k = cand_s1;
			next_b.w = wc_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next <= '0;
		end else if (en) begin
			next <= next_b;
		end
	end

endmodule

`default_nettype wire

### src/brush_tip_mask_pixel.sv
// Brush tip alpha mask, one tip pixel per beat.
//
// The pix channel takes a pixel_x / pixel_y coordinate of the n-by-n tip;
// the mask channel returns that pixel's 8-bit alpha for the configured
// shape (round, soft, square or angled). Coordinates at or beyond the
// size give 0. The user must write brush_size, tip_shape and hardness via
// the cfg_wr_en / cfg_index / cfg_data port only while no beat is in
// flight; the block does not enforce it. A write to index 3 is dropped.
//
// A new beat is taken every cycle while the output is not stalled. A
// result passes through 22 register stages in all: five geometry stages,
// two stages for each of the eight bits of the soft falloff search, and
// the output register. Every shape takes the same path, so order is kept.
//
// When the receiver holds ready low with a result waiting, the whole
// pipeline freezes and pix.ready drops in the same cycle; nothing is lost
// or repeated. Reset empties the pipeline and loads size 8, round shape
// and hardness 128.

`default_nettype none

module brush_tip_mask_pixel import btm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	btm_pix_if.sink               pix,
	btm_alpha_if.source           mask,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [SIZE_W-1:0]  brush_size_q;
	btm_shape_t         tip_shape_q;
	logic [HARD_W-1:0]  hardness_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brush_size_q <= SIZE_W'(8);
			tip_shape_q  <= SHAPE_ROUND;
			hardness_q   <= HARD_W'(128);
		end else if (cfg_wr_en) begin
			unique case (btm_reg_t'(cfg_index))
				REG_BRUSH_SIZE: brush_size_q <= cfg_data[SIZE_W-1:0];
				REG_TIP_SHAPE:  tip_shape_q  <= btm_shape_t'(cfg_data[SHAPE_W-1:0]);
				REG_HARDNESS:   hardness_q   <= cfg_data[HARD_W-1:0];
				default: ;
			endcase
		end
	end

	logic               en;
	logic               out_vld_q;
	logic [ALPHA_W-1:0] alpha_q;
	btm_srch_t          chain [0:8];

	// The pipeline moves as one whenever the output register can be freed.
	assign en        = !out_vld_q || mask.ready;
	assign pix.ready = en;

	btm_geom u_geom (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_vld     (pix.valid),
		.pixel_x    (pix.pixel_x),
		.pixel_y    (pix.pixel_y),
		.brush_size (brush_size_q),
		.tip_shape  (tip_shape_q),
		.hardness   (hardness_q),
		.res        (chain[0])
	);

	for (genvar i = 0; i < 8; i++) begin : g_step
		btm_step u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.shamt  (3'(7 - i)),
			.prev   (chain[i]),
			.next   (chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= chain[8].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			alpha_q <= chain[8].srch ? chain[8].k : chain[8].a;
		end
	end

	assign mask.valid = out_vld_q;
	assign mask.alpha = alpha_q;

	// A stall freezes the head of the search chain.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(chain[0].vld))
		else $error("pipeline moved during a stall");

	// Outside the core the falloff stays below full alpha.
	a_falloff_below_full: assert property (@(posedge clk) disable iff (!arst_n)
		chain[8].vld && chain[8].srch |-> chain[8].k != ALPHA_FULL)
		else $error("soft falloff reached full alpha");

	// A result only appears when the last search stage held an item.
	a_out_from_chain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(chain[8].vld))
		else $error("output valid without an item behind it");

endmodule

`default_nettype wire

### test/brush_tip_mask_pixel_test.sv
`timescale 1ns / 1ps

module brush_tip_mask_pixel_test;
	import btm_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int RANDOM_PHASES  = 20;
	localparam int PHASE_ITEMS    = 100;
	localparam int LONG_HOLD      = 300;
	localparam int QUIET_LIMIT    = 2000;
	localparam int DRAIN_CYCLES   = 40;

	localparam logic [CFG_DATA_W-1:0] SIZE_EDGES [10] =
		'{8'd0, 8'd1, 8'd2, 8'd63, 8'd64, 8'd65, 8'd127, 8'd128, 8'd200, 8'd255};
	localparam logic [CFG_DATA_W-1:0] HARD_EDGES [4] = '{8'd0, 8'd1, 8'd254, 8'd255};

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} coord_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	btm_pix_if pix ();
	btm_alpha_if mask ();

	brush_tip_mask_pixel DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix),
		.mask      (mask),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Register copies as the block should hold them.
	logic [SIZE_W-1:0] cur_size = 7'd8;
	btm_shape_t        cur_shape = SHAPE_ROUND;
	logic [HARD_W-1:0] cur_hard = 8'd128;

	coord_t coord_q[$];
	logic [ALPHA_W-1:0] want_alpha_q[$];
	logic [ALPHA_W-1:0] want;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	bit long_hold_go = 1'b0;
	bit long_hold_done = 1'b0;
	int long_hold_cnt = 0;

	function automatic longint tip_size();
		longint s;
		s = longint'(cur_size);
		if (s < 1)
			s = 1;
		if (s > longint'(MAX_SIZE))
			s = longint'(MAX_SIZE);
		return s;
	endfunction

	// True when c * sqrt(d2) <= w, all in integers.
	function automatic bit root_within(longint c, longint d2, longint w);
		return w >= 0 && c * c * d2 <= w * w;
	endfunction

	function automatic logic [ALPHA_W-1:0] tip_alpha(logic [COORD_W-1:0] px,
			logic [COORD_W-1:0] py);
		longint n, cx, cy, d2, h, k, cand, bitv, lim;
		n = tip_size();
		if (longint'(px) >= n || longint'(py) >= n)
			return ALPHA_NONE;
		// Doubled coordinates about the tip centre; the doubled radius is n.
		cx = 2 * longint'(px) - (n - 1);
		cy = 2 * longint'(py) - (n - 1);
		d2 = cx * cx + cy * cy;
		case (cur_shape)
			SHAPE_ROUND: begin
				return (d2 <= n * n) ? ALPHA_FULL : ALPHA_NONE;
			end
			SHAPE_SQUARE: begin
				return ALPHA_FULL;
			end
			SHAPE_ANGLED: begin
				lim = 7 * n + 20;
				if (200 * (cx + cy) * (cx + cy) <= lim * lim &&
						(cy - cx) * (cy - cx) <= 2 * n * n)
					return ALPHA_FULL;
				return ALPHA_NONE;
			end
			default: begin
				h = longint'(cur_hard);
				if (d2 > n * n)
					return ALPHA_NONE;
				if (root_within(255, d2, n * h))
					return ALPHA_FULL;
				// Largest k with k*n*(255-h) <= 65025*(n - sqrt(d2)), bit by bit.
				k = 0;
				for (bitv = 128; bitv > 0; bitv = bitv >> 1) begin
					cand = k | bitv;
					if (root_within(65025, d2, 65025 * n - cand * n * (255 - h)))
						k = cand;
				end
				return ALPHA_W'(k);
			end
		endcase
	endfunction

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_BRUSH_SIZE: cur_size = data[SIZE_W-1:0];
			REG_TIP_SHAPE:  cur_shape = btm_shape_t'(data[SHAPE_W-1:0]);
			REG_HARDNESS:   cur_hard = data;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic queue_coord(int x, int y);
		coord_t c;
		c.x = COORD_W'(x);
		c.y = COORD_W'(y);
		coord_q.push_back(c);
	endtask

	// Waits at falling edges until every beat has gone in and come out.
	task automatic settle();
		do
			@(negedge clk);
		while (coord_q.size() != 0 || want_alpha_q.size() != 0 || pix.valid);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Pixel sender.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix.valid <= 1'b0;
			pix.pixel_x <= '0;
			pix.pixel_y <= '0;
		end else begin
			if (pix.valid && pix.ready)
				void'(coord_q.pop_front());
			if (!pix.valid || pix.ready) begin
				if (coord_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					pix.valid <= 1'b1;
					pix.pixel_x <= coord_q[0].x;
					pix.pixel_y <= coord_q[0].y;
				end else begin
					pix.valid <= 1'b0;
				end
			end
		end
	end

	// Mask receiver, with one long hold-off when asked for.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask.ready <= 1'b0;
		end else if (long_hold_go && !long_hold_done) begin
			mask.ready <= 1'b0;
			long_hold_cnt++;
			if (long_hold_cnt >= LONG_HOLD)
				long_hold_done = 1'b1;
		end else begin
			mask.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Predicts on each accepted pixel beat and checks each mask beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pix.valid && pix.ready)
				want_alpha_q.push_back(tip_alpha(pix.pixel_x, pix.pixel_y));
			if (mask.valid && mask.ready) begin
				if (want_alpha_q.size() == 0) begin
					$error("alpha: expected nothing, got %0d", mask.alpha);
					mismatches++;
				end else begin
					want = want_alpha_q.pop_front();
					if (mask.alpha !== want) begin
						$error("alpha: expected %0d, got %0d", want, mask.alpha);
						mismatches++;
					end
				end
			end
			if ((pix.valid && pix.ready) || (mask.valid && mask.ready) ||
					(!pix.valid && want_alpha_q.size() == 0))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("brush_tip_mask_pixel regression: fail");
				$finish;
			end
		end
	end

	initial begin
		int n;
		int mode;
		logic [CFG_DATA_W-1:0] size_data;
		logic [CFG_DATA_W-1:0] hard_data;

		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: size 8, round disc.
		queue_coord(0, 0);
		queue_coord(3, 3);
		queue_coord(7, 7);
		queue_coord(8, 3);
		queue_coord(0, 63);
		queue_coord(63, 63);
		settle();

		// Fully soft at the largest size: the falloff runs from the centre.
		set_reg(REG_BRUSH_SIZE, 8'd64);
		set_reg(REG_TIP_SHAPE, CFG_DATA_W'(SHAPE_SOFT));
		set_reg(REG_HARDNESS, 8'd0);
		queue_coord(31, 31);
		queue_coord(32, 10);
		queue_coord(0, 0);
		queue_coord(63, 31);
		settle();

		// Fully hard: the whole disc is core.
		set_reg(REG_HARDNESS, 8'd255);
		queue_coord(31, 31);
		queue_coord(2, 20);
		settle();

		// A size of zero acts as one.
		set_reg(REG_TIP_SHAPE, CFG_DATA_W'(SHAPE_SQUARE));
		set_reg(REG_BRUSH_SIZE, 8'd0);
		queue_coord(0, 0);
		queue_coord(1, 0);
		queue_coord(0, 1);
		settle();

		// 200 keeps 72 in seven bits, which is clamped to the largest size.
		set_reg(REG_TIP_SHAPE, CFG_DATA_W'(SHAPE_ANGLED));
		set_reg(REG_BRUSH_SIZE, 8'd200);
		queue_coord(0, 0);
		queue_coord(31, 32);
		queue_coord(63, 63);
		queue_coord(0, 63);
		settle();

		// A write to the spare index must leave every register alone.
		set_reg(REG_SPARE, 8'd1);
		queue_coord(10, 12);
		queue_coord(40, 41);
		settle();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			mode = phase % 4;
			send_idle_pct = (mode == 1) ? 62 : (mode == 3) ? 23 : 0;
			recv_stall_pct = (mode == 2) ? 62 : (mode == 3) ? 23 : 0;

			if (phase % 5 == 2)
				set_reg(REG_SPARE, CFG_DATA_W'($urandom_range(255)));
			if ($urandom_range(3) == 0)
				size_data = SIZE_EDGES[$urandom_range(9)];
			else
				size_data = CFG_DATA_W'($urandom_range(64, 1));
			if ($urandom_range(3) == 0)
				hard_data = HARD_EDGES[$urandom_range(3)];
			else
				hard_data = CFG_DATA_W'($urandom_range(255));
			set_reg(REG_HARDNESS, hard_data);
			set_reg(REG_BRUSH_SIZE, size_data);
			set_reg(REG_TIP_SHAPE, CFG_DATA_W'($urandom_range(3)));

			n = int'(tip_size());
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (phase == 9 && i == PHASE_ITEMS / 2)
					settle();
				// Mostly inside the tip, so the shape logic gets exercised.
				if ($urandom_range(99) < 85)
					queue_coord($urandom_range(n - 1), $urandom_range(n - 1));
				else
					queue_coord($urandom_range(63), $urandom_range(63));
			end
			// The receiver sits out a long stretch while the sender keeps offering.
			if (phase == 4)
				long_hold_go = 1'b1;
			settle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("brush_tip_mask_pixel regression: pass");
		else
			$display("brush_tip_mask_pixel regression: fail");
		$finish;
	end

endmodule
